@@ hdl/battery_level_hysteresis_monitor_unit_macros.svh @@
// Assertion macros for the battery level hysteresis monitor.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef BATTERY_LEVEL_HYSTERESIS_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_HYSTERESIS_MONITOR_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BLHM_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define BLHM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/blhm_pkg.sv @@
// Package for the battery level hysteresis monitor: widths, reset values and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blhm_pkg;

   localparam int ADC_BITS_DEFAULT = 10;
   localparam int TIMER_W = 16;
   localparam int LEVEL_W = 4;
   localparam int LEVEL_COUNT = 8;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   localparam logic [TIMER_W-1:0] PERIOD_RESET = 16'd100;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = 4'd8;

   typedef enum logic [2:0] {
      REG_THR_LOW  = 3'd0,
      REG_THR_HIGH = 3'd1,
      REG_HYS_LOW  = 3'd2,
      REG_HYS_HIGH = 3'd3,
      REG_PERIOD   = 3'd4
   } csr_reg_type;

endpackage

`default_nettype wire

@@ hdl/blhm_csr.sv @@
// Configuration register file of the battery level hysteresis monitor (APB-style port).
// Depends on blhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blhm_csr #(
   parameter int ADC_BITS = blhm_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [blhm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [blhm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [blhm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output logic      [8*ADC_BITS-1:0]               thresholds,
   output logic      [8*ADC_BITS-1:0]               hysteresis,
   output logic      [blhm_pkg::TIMER_W-1:0]        period
);

   localparam int HALF_W = 4 * ADC_BITS;

   logic [HALF_W-1:0]              thr_low_ff, thr_high_ff, hys_low_ff, hys_high_ff;
   logic [blhm_pkg::TIMER_W-1:0]   period_ff;
   logic                           write_en;
   logic [2:0]                     reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_low_ff  <= '0;
         thr_high_ff <= '0;
         hys_low_ff  <= '0;
         hys_high_ff <= '0;
         period_ff   <= blhm_pkg::PERIOD_RESET;
      end else if (write_en) begin
         case (reg_index)
            blhm_pkg::REG_THR_LOW:  thr_low_ff  <= csr_pwdata[HALF_W-1:0];
            blhm_pkg::REG_THR_HIGH: thr_high_ff <= csr_pwdata[HALF_W-1:0];
            blhm_pkg::REG_HYS_LOW:  hys_low_ff  <= csr_pwdata[HALF_W-1:0];
            blhm_pkg::REG_HYS_HIGH: hys_high_ff <= csr_pwdata[HALF_W-1:0];
            blhm_pkg::REG_PERIOD:   period_ff   <= csr_pwdata[blhm_pkg::TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         blhm_pkg::REG_THR_LOW:  csr_prdata = blhm_pkg::CSR_DATA_W'(thr_low_ff);
         blhm_pkg::REG_THR_HIGH: csr_prdata = blhm_pkg::CSR_DATA_W'(thr_high_ff);
         blhm_pkg::REG_HYS_LOW:  csr_prdata = blhm_pkg::CSR_DATA_W'(hys_low_ff);
         blhm_pkg::REG_HYS_HIGH: csr_prdata = blhm_pkg::CSR_DATA_W'(hys_high_ff);
         blhm_pkg::REG_PERIOD:   csr_prdata = blhm_pkg::CSR_DATA_W'(period_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign thresholds = {thr_high_ff, thr_low_ff};
   assign hysteresis = {hys_high_ff, hys_low_ff};
   assign period     = period_ff;

endmodule

`default_nettype wire

@@ hdl/blhm_level_update.sv @@
// Next-level logic for one channel: band exit test with hysteresis and requantization.
// Depends on blhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blhm_level_update #(
   parameter int ADC_BITS = blhm_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic [blhm_pkg::LEVEL_W-1:0] level,
   input  wire logic [ADC_BITS-1:0]          reading,
   input  wire logic [8*ADC_BITS-1:0]        thresholds,
   input  wire logic [8*ADC_BITS-1:0]        hysteresis,
   output logic      [blhm_pkg::LEVEL_W-1:0] next_level
);

   logic [2:0]                         upper_idx, lower_idx;
   logic [ADC_BITS-1:0]                thr_up, hys_up, thr_dn, hys_dn, low_bound;
   logic [ADC_BITS:0]                  high_bound;
   logic                               exit_up, exit_dn;
   logic [blhm_pkg::LEVEL_W-1:0]       quant;

   assign upper_idx  = level[2:0];
   assign lower_idx  = 3'(level - 4'd1);
   assign thr_up     = thresholds[upper_idx*ADC_BITS +: ADC_BITS];
   assign hys_up     = hysteresis[upper_idx*ADC_BITS +: ADC_BITS];
   assign thr_dn     = thresholds[lower_idx*ADC_BITS +: ADC_BITS];
   assign hys_dn     = hysteresis[lower_idx*ADC_BITS +: ADC_BITS];
   assign high_bound = {1'b0, thr_up} + {1'b0, hys_up};
   assign low_bound  = (thr_dn > hys_dn) ? (thr_dn - hys_dn) : '0;
   assign exit_up    = (level < blhm_pkg::TOP_LEVEL) && ({1'b0, reading} > high_bound);
   assign exit_dn    = (level != '0) && (reading < low_bound);

   // The highest level whose threshold lies below the reading wins.
   always_comb begin
      quant = '0;
      for (int k = 1; k <= blhm_pkg::LEVEL_COUNT; k++) begin
         if (reading > thresholds[(k-1)*ADC_BITS +: ADC_BITS]) begin
            quant = blhm_pkg::LEVEL_W'(k);
         end
      end
   end

   assign next_level = (exit_up || exit_dn) ? quant : level;

endmodule

`default_nettype wire

@@ hdl/battery_level_hysteresis_monitor_unit.sv @@
// Top level of the battery level hysteresis monitor: input register, update timer, level state
// and result register. Depends on blhm_pkg, blhm_csr, blhm_level_update and the macros header.
`timescale 1ns / 1ps
`default_nettype none

// The monitor takes one tick transaction per clock cycle while req_tready is high and returns
// exactly one result transaction per tick. Each tick is latched in an input register, then the
// countdown timer and both channel levels are updated by combinational compare logic and
// written to the result register; the next tick already sees the new state, so ticks may
// arrive back to back. Stalls on the result side hold the result and, once the input register
// is also full, lower req_tready. Thresholds, hysteresis and the update period are written
// through the csr_ port; the user must write them only while idle, as the block does not enforce it.
module battery_level_hysteresis_monitor_unit #(
   parameter int ADC_BITS = blhm_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // elapsed_ms, charger_reading, battery_reading (from bit 0 up), zero filled to bytes.
   input  wire logic [((blhm_pkg::TIMER_W + 2*ADC_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // charger_level, battery_level, is_charging, levels_updated (from bit 0 up), zero filled.
   output logic      [blhm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [blhm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [blhm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [blhm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

`include "battery_level_hysteresis_monitor_unit_macros.svh"

   localparam int TW = blhm_pkg::TIMER_W;
   localparam int LW = blhm_pkg::LEVEL_W;

   logic [8*ADC_BITS-1:0]  thresholds, hysteresis;
   logic [TW-1:0]          period;

   logic                   in_valid_ff, in_valid_in;
   logic [TW-1:0]          in_elapsed_ff;
   logic [ADC_BITS-1:0]    in_charger_ff, in_battery_ff;

   logic [TW-1:0]          countdown_ff, countdown_in, remaining;
   logic [LW-1:0]          charger_ff, charger_in, battery_ff, battery_in;
   logic [LW-1:0]          charger_next, battery_next;
   logic                   charging_ff, charging_in;
   logic                   do_update, advance, accept;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [blhm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   blhm_csr #(.ADC_BITS(ADC_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thresholds  (thresholds),
      .hysteresis  (hysteresis),
      .period      (period)
   );

   blhm_level_update #(.ADC_BITS(ADC_BITS)) u_charger (
      .level      (charger_ff),
      .reading    (in_charger_ff),
      .thresholds (thresholds),
      .hysteresis (hysteresis),
      .next_level (charger_next)
   );

   blhm_level_update #(.ADC_BITS(ADC_BITS)) u_battery (
      .level      (battery_ff),
      .reading    (in_battery_ff),
      .thresholds (thresholds),
      .hysteresis (hysteresis),
      .next_level (battery_next)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   assign remaining    = (countdown_ff > in_elapsed_ff) ? (countdown_ff - in_elapsed_ff) : '0;
   assign do_update    = (remaining == '0);
   assign countdown_in = do_update ? period : remaining;
   assign charger_in   = do_update ? charger_next : charger_ff;
   assign battery_in   = do_update ? battery_next : battery_ff;
   assign charging_in  = do_update ? ((charger_next >= battery_next) && (charger_next != '0))
                                   : charging_ff;

   assign rsp_data_in  = blhm_pkg::RSP_DATA_W'({do_update, charging_in, battery_in, charger_in});
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         countdown_ff <= blhm_pkg::PERIOD_RESET;
         charger_ff   <= '0;
         battery_ff   <= '0;
         charging_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            countdown_ff <= countdown_in;
            charger_ff   <= charger_in;
            battery_ff   <= battery_in;
            charging_ff  <= charging_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_elapsed_ff <= req_tdata[TW-1:0];
         in_charger_ff <= req_tdata[TW +: ADC_BITS];
         in_battery_ff <= req_tdata[TW+ADC_BITS +: ADC_BITS];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BLHM_ASSERT_ALWAYS(a_level_range, (charger_ff <= blhm_pkg::TOP_LEVEL) && (battery_ff <= blhm_pkg::TOP_LEVEL), "level out of range")
   `BLHM_ASSERT_ALWAYS(a_charging_consistent, charging_ff == ((charger_ff >= battery_ff) && (charger_ff != '0)), "charging flag disagrees with levels")
   `BLHM_ASSERT_NEXT(a_hold_without_update, advance && !do_update, $stable(charger_ff) && $stable(battery_ff) && (countdown_ff != '0), "levels moved without an update")
   `BLHM_ASSERT_NEXT(a_result_held, rsp_valid_ff && !rsp_tready, rsp_valid_ff && $stable(rsp_data_ff), "stalled result changed")

endmodule

`default_nettype wire

@@ bench/battery_level_hysteresis_monitor_unit_tb.sv @@
// Self-checking testbench for battery_level_hysteresis_monitor_unit: directed and random ticks,
// a per-tick level predictor and an APB-style register programmer with read-back.
// Depends on blhm_pkg and the battery_level_hysteresis_monitor_unit RTL.
`timescale 1ns / 1ps

module battery_level_hysteresis_monitor_unit_tb;

   localparam int ADC_W = blhm_pkg::ADC_BITS_DEFAULT;
   localparam int TIMER_W = blhm_pkg::TIMER_W;
   localparam int LEVEL_W = blhm_pkg::LEVEL_W;
   localparam int LEVEL_COUNT = blhm_pkg::LEVEL_COUNT;
   localparam int CSR_ADDR_W = blhm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = blhm_pkg::CSR_DATA_W;
   localparam int RSP_DATA_W = blhm_pkg::RSP_DATA_W;
   localparam logic [TIMER_W-1:0] PERIOD_RESET = blhm_pkg::PERIOD_RESET;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = blhm_pkg::TOP_LEVEL;
   localparam int REQ_DATA_W = ((TIMER_W + 2 * ADC_W + 7) / 8) * 8;
   localparam int REG_STRIDE = 8;
   localparam int UNMAPPED_REG = 5;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 10;
   localparam int TICKS_PER_PHASE = 50;

   typedef struct {
      logic [TIMER_W-1:0] elapsed;
      logic [ADC_W-1:0]   charger;
      logic [ADC_W-1:0]   battery;
      bit                 hold_for_drain;
   } tick_item_type;

   typedef struct {
      logic [LEVEL_W-1:0] charger_level;
      logic [LEVEL_W-1:0] battery_level;
      logic               is_charging;
      logic               levels_updated;
   } level_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   battery_level_hysteresis_monitor_unit #(.ADC_BITS(ADC_W)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the register file and the level state.
   logic [8*ADC_W-1:0] thresholds_q = '0;
   logic [8*ADC_W-1:0] hysteresis_q = '0;
   logic [TIMER_W-1:0] reload_period = PERIOD_RESET;
   logic [TIMER_W-1:0] countdown_ms = PERIOD_RESET;
   logic [LEVEL_W-1:0] charger_level_q = '0;
   logic [LEVEL_W-1:0] battery_level_q = '0;
   logic               charging_q = 1'b0;

   tick_item_type    tick_queue[$];
   level_report_type level_reports_due[$];
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   logic             req_fire = 1'b0;

   function automatic logic [ADC_W-1:0] threshold_at(int k);
      return thresholds_q[(k - 1) * ADC_W +: ADC_W];
   endfunction

   function automatic logic [ADC_W-1:0] hysteresis_at(int k);
      return hysteresis_q[(k - 1) * ADC_W +: ADC_W];
   endfunction

   function automatic logic [LEVEL_W-1:0] quantize_reading(logic [ADC_W-1:0] reading);
      logic [LEVEL_W-1:0] lvl;
      lvl = '0;
      for (int k = 1; k <= LEVEL_COUNT; k++) begin
         if (reading > threshold_at(k)) begin
            lvl = LEVEL_W'(k);
         end
      end
      return lvl;
   endfunction

   function automatic logic [LEVEL_W-1:0] step_level(logic [LEVEL_W-1:0] level,
                                                     logic [ADC_W-1:0] reading);
      logic [ADC_W:0]   upper;
      logic [ADC_W-1:0] thr;
      logic [ADC_W-1:0] hys;
      logic [ADC_W-1:0] lower;
      bit               leave;
      leave = 1'b0;
      if (level < TOP_LEVEL) begin
         upper = {1'b0, threshold_at(int'(level) + 1)} +
                 {1'b0, hysteresis_at(int'(level) + 1)};
         if ({1'b0, reading} > upper) begin
            leave = 1'b1;
         end
      end
      if (level > 0) begin
         thr = threshold_at(int'(level));
         hys = hysteresis_at(int'(level));
         lower = (thr > hys) ? thr - hys : '0;
         if (reading < lower) begin
            leave = 1'b1;
         end
      end
      return leave ? quantize_reading(reading) : level;
   endfunction

   function automatic level_report_type predict_tick(tick_item_type t);
      level_report_type r;
      countdown_ms = (countdown_ms > t.elapsed) ? countdown_ms - t.elapsed : '0;
      r.levels_updated = 1'b0;
      if (countdown_ms == 0) begin
         countdown_ms = reload_period;
         charger_level_q = step_level(charger_level_q, t.charger);
         battery_level_q = step_level(battery_level_q, t.battery);
         charging_q = (charger_level_q >= battery_level_q) && (charger_level_q != 0);
         r.levels_updated = 1'b1;
      end
      r.charger_level = charger_level_q;
      r.battery_level = battery_level_q;
      r.is_charging = charging_q;
      return r;
   endfunction

   function automatic void apply_register(int idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         blhm_pkg::REG_THR_LOW:  thresholds_q[4*ADC_W-1:0] = value[4*ADC_W-1:0];
         blhm_pkg::REG_THR_HIGH: thresholds_q[8*ADC_W-1:4*ADC_W] = value[4*ADC_W-1:0];
         blhm_pkg::REG_HYS_LOW:  hysteresis_q[4*ADC_W-1:0] = value[4*ADC_W-1:0];
         blhm_pkg::REG_HYS_HIGH: hysteresis_q[8*ADC_W-1:4*ADC_W] = value[4*ADC_W-1:0];
         blhm_pkg::REG_PERIOD:   reload_period = value[TIMER_W-1:0];
         default:                ;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] register_value(int idx);
      logic [CSR_DATA_W-1:0] v;
      v = '0;
      case (idx)
         blhm_pkg::REG_THR_LOW:  v[4*ADC_W-1:0] = thresholds_q[4*ADC_W-1:0];
         blhm_pkg::REG_THR_HIGH: v[4*ADC_W-1:0] = thresholds_q[8*ADC_W-1:4*ADC_W];
         blhm_pkg::REG_HYS_LOW:  v[4*ADC_W-1:0] = hysteresis_q[4*ADC_W-1:0];
         blhm_pkg::REG_HYS_HIGH: v[4*ADC_W-1:0] = hysteresis_q[8*ADC_W-1:4*ADC_W];
         blhm_pkg::REG_PERIOD:   v[TIMER_W-1:0] = reload_period;
         default:                ;
      endcase
      return v;
   endfunction

   function automatic void queue_tick(int elapsed, int charger, int battery, bit hold);
      tick_item_type t;
      t.elapsed = TIMER_W'(elapsed);
      t.charger = ADC_W'(charger);
      t.battery = ADC_W'(battery);
      t.hold_for_drain = hold;
      tick_queue.push_back(t);
   endfunction

   // Picks a reading around the band edges of a random level.
   function automatic int reading_near_band();
      int k;
      int h;
      int c;
      k = $urandom_range(1, LEVEL_COUNT);
      h = int'(hysteresis_at(k));
      c = int'(threshold_at(k)) + int'($urandom_range(0, 2 * h + 6)) - (h + 3);
      if (c < 0) begin
         c = 0;
      end
      if (c > (1 << ADC_W) - 1) begin
         c = (1 << ADC_W) - 1;
      end
      return c;
   endfunction

   task automatic write_register(input int idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(idx * REG_STRIDE);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(idx, value);
      @(negedge clock);
      if (idx <= int'(blhm_pkg::REG_PERIOD)) begin
         csr_pwrite <= 1'b0;
         csr_penable <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         readback = csr_prdata;
         if (readback !== register_value(idx)) begin
            $display("%0t: register %0d read-back mismatch, expected %h actual %h",
                     $time, idx, register_value(idx), readback);
            mismatch_count++;
         end
         @(negedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Checked at the rising edge, where the driver's outputs are settled.
   task automatic wait_until_idle();
      while (tick_queue.size() != 0 || req_tvalid || level_reports_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Tick driver: a new transaction is presented only after the previous one was accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_fire || !req_tvalid) begin
            if (tick_queue.size() != 0 &&
                !(tick_queue[0].hold_for_drain && level_reports_due.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= {{(REQ_DATA_W - TIMER_W - 2 * ADC_W){1'b0}},
                             tick_queue[0].battery, tick_queue[0].charger,
                             tick_queue[0].elapsed};
               req_tvalid <= 1'b1;
               void'(tick_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Result monitor, predictor and watchdog.
   always @(posedge clock) begin
      level_report_type want;
      tick_item_type    seen;
      if (reset) begin
         req_fire <= 1'b0;
         stall_cycles = 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (level_reports_due.size() == 0) begin
               $display("%0t: result transaction with no tick outstanding, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = level_reports_due.pop_front();
               if (rsp_tdata[3:0] !== want.charger_level ||
                   rsp_tdata[7:4] !== want.battery_level ||
                   rsp_tdata[8] !== want.is_charging ||
                   rsp_tdata[9] !== want.levels_updated) begin
                  $display("%0t: level report mismatch, expected chg %0d bat %0d charging %0d upd %0d, actual chg %0d bat %0d charging %0d upd %0d",
                           $time, want.charger_level, want.battery_level, want.is_charging,
                           want.levels_updated, rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[8],
                           rsp_tdata[9]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen.elapsed = req_tdata[TIMER_W-1:0];
            seen.charger = req_tdata[TIMER_W +: ADC_W];
            seen.battery = req_tdata[TIMER_W + ADC_W +: ADC_W];
            seen.hold_for_drain = 1'b0;
            level_reports_due.push_back(predict_tick(seen));
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("battery_level_hysteresis_monitor_unit_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [ADC_W-1:0]  thr_pick[8];
      logic [ADC_W-1:0]  hys_pick[8];
      logic [TIMER_W-1:0] period_pick;
      bit                ordered;
      int                base;
      int                elapsed;
      int                chg;
      int                bat;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 51;

      // Reset configuration: all thresholds zero, period 100.
      queue_tick(0, 0, 0, 1'b0);
      queue_tick(16'hFFFF, 1023, 1023, 1'b0);
      queue_tick(99, 0, 1023, 1'b0);
      queue_tick(1, 0, 1023, 1'b0);
      wait_until_idle();

      write_register(blhm_pkg::REG_THR_LOW, {24'h0, 10'd400, 10'd300, 10'd200, 10'd100});
      write_register(blhm_pkg::REG_THR_HIGH, {24'h0, 10'd800, 10'd700, 10'd600, 10'd500});
      write_register(blhm_pkg::REG_HYS_LOW, {24'hFFFFFF, {4{10'd20}}});
      write_register(blhm_pkg::REG_HYS_HIGH, {24'h0, {4{10'd20}}});
      write_register(blhm_pkg::REG_PERIOD, 64'd1);
      queue_tick(1, 0, 0, 1'b0);
      queue_tick(1, 150, 850, 1'b0);
      queue_tick(1, 115, 790, 1'b0);
      queue_tick(1, 79, 779, 1'b0);
      queue_tick(1, 1023, 0, 1'b0);
      queue_tick(1, 0, 1023, 1'b1);
      wait_until_idle();

      // Largest thresholds, hysteresis and period.
      write_register(blhm_pkg::REG_THR_LOW, {24'h0, {4{10'h3FF}}});
      write_register(blhm_pkg::REG_THR_HIGH, {24'h0, {4{10'h3FF}}});
      write_register(blhm_pkg::REG_HYS_LOW, {24'h0, {4{10'h3FF}}});
      write_register(blhm_pkg::REG_HYS_HIGH, {24'h0, {4{10'h3FF}}});
      write_register(blhm_pkg::REG_PERIOD, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_tick(16'hFFFF, 1023, 0, 1'b0);
      queue_tick(16'h8000, 512, 512, 1'b0);
      queue_tick(16'h7FFF, 512, 512, 1'b0);
      wait_until_idle();

      // Zero thresholds under full hysteresis: the lower band edge saturates.
      write_register(blhm_pkg::REG_THR_LOW, 64'h0);
      write_register(blhm_pkg::REG_THR_HIGH, 64'h0);
      queue_tick(16'hFFFF, 0, 0, 1'b0);
      queue_tick(16'hFFFF, 1023, 1023, 1'b0);
      wait_until_idle();

      // Zero period: every tick after the reload updates.
      write_register(blhm_pkg::REG_HYS_LOW, 64'h0);
      write_register(blhm_pkg::REG_HYS_HIGH, 64'h0);
      write_register(UNMAPPED_REG, {$urandom, $urandom});
      write_register(blhm_pkg::REG_PERIOD, 64'h0);
      queue_tick(16'hFFFF, 0, 0, 1'b0);
      queue_tick(0, 600, 3, 1'b0);
      queue_tick(0, 5, 1000, 1'b0);
      wait_until_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 9;
            recv_idle_pct = 51;
         end else if (phase < 7) begin
            send_idle_pct = 51;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         ordered = ($urandom_range(0, 3) != 0);
         base = 0;
         for (int k = 0; k < 8; k++) begin
            if (ordered) begin
               base = base + int'($urandom_range(0, 140));
               if (base > 1023) begin
                  base = 1023;
               end
               thr_pick[k] = ADC_W'(base);
            end else begin
               thr_pick[k] = ADC_W'($urandom_range(0, 1023));
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 8; k++) begin
               hys_pick[k] = ADC_W'($urandom_range(0, 40));
            end
         end else begin
            for (int k = 0; k < 8; k++) begin
               hys_pick[k] = ADC_W'($urandom_range(0, 1023));
            end
         end
         case ($urandom_range(0, 5))
            0, 1, 2, 3: period_pick = TIMER_W'($urandom_range(1, 4));
            4:          period_pick = TIMER_W'($urandom_range(1, 65535));
            default:    period_pick = 16'hFFFF;
         endcase
         write_register(blhm_pkg::REG_THR_LOW, {24'($urandom), thr_pick[3], thr_pick[2],
                                                thr_pick[1], thr_pick[0]});
         write_register(blhm_pkg::REG_THR_HIGH, {24'($urandom), thr_pick[7], thr_pick[6],
                                                 thr_pick[5], thr_pick[4]});
         write_register(blhm_pkg::REG_HYS_LOW, {24'($urandom), hys_pick[3], hys_pick[2],
                                                hys_pick[1], hys_pick[0]});
         write_register(blhm_pkg::REG_HYS_HIGH, {24'($urandom), hys_pick[7], hys_pick[6],
                                                 hys_pick[5], hys_pick[4]});
         write_register(blhm_pkg::REG_PERIOD, {$urandom, 16'($urandom), period_pick});
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               elapsed = $urandom_range(0, 65535);
            end else begin
               elapsed = $urandom_range(0, 3);
            end
            chg = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1023))
                                               : reading_near_band();
            bat = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1023))
                                               : reading_near_band();
            queue_tick(elapsed, chg, bat, n == TICKS_PER_PHASE / 2);
         end
         wait_until_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("battery_level_hysteresis_monitor_unit_tb OK");
      end else begin
         $display("battery_level_hysteresis_monitor_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
